// ===== hdl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the one-wire bus master: command codes,
// phase and operation codes, register indexes, the register set and the
// per-beat status record.
// ----------------------------------------------------------------------------
package owbm_pkg;

	// Width of every phase-length register and of the tick counter
	localparam int TICK_W = 8;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;

	// Default byte length in bit slots
	localparam int BITS_PER_BYTE_DEF = 8;

	// Fixed lengths of the read low and read wait phases
	localparam logic [TICK_W-1:0] READ_LOW_TICKS = 8'd1;
	localparam logic [TICK_W-1:0] READ_WAIT_TICKS = 8'd1;

	// Command codes carried on the input tuser
	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_RESET = 2'd1,
		FN_WRITE = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	// Last operation started
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Bus phase, one-hot
	typedef enum logic [8:0] {
		PH_IDLE     = 9'b000000001,
		PH_RST_LOW  = 9'b000000010,
		PH_RST_WAIT = 9'b000000100,
		PH_RST_TAIL = 9'b000001000,
		PH_WR_LOW   = 9'b000010000,
		PH_WR_TAIL  = 9'b000100000,
		PH_RD_LOW   = 9'b001000000,
		PH_RD_WAIT  = 9'b010000000,
		PH_RD_TAIL  = 9'b100000000
	} phase_t;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESET_LOW      = 3'd0,
		REG_PRESENCE_WAIT  = 3'd1,
		REG_RESET_TAIL     = 3'd2,
		REG_WRITE_ONE_LOW  = 3'd3,
		REG_WRITE_ONE_TAIL = 3'd4,
		REG_WRITE_ZERO_LOW = 3'd5,
		REG_WRITE_ZERO_TAIL = 3'd6,
		REG_READ_TAIL      = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [TICK_W-1:0] RESET_LOW_DEF       = 8'd100;
	localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEF   = 8'd20;
	localparam logic [TICK_W-1:0] RESET_TAIL_DEF      = 8'd100;
	localparam logic [TICK_W-1:0] WRITE_ONE_LOW_DEF   = 8'd2;
	localparam logic [TICK_W-1:0] WRITE_ONE_TAIL_DEF  = 8'd15;
	localparam logic [TICK_W-1:0] WRITE_ZERO_LOW_DEF  = 8'd15;
	localparam logic [TICK_W-1:0] WRITE_ZERO_TAIL_DEF = 8'd4;
	localparam logic [TICK_W-1:0] READ_TAIL_DEF       = 8'd10;

	// Phase lengths handed to the sequencer
	typedef struct packed {
		logic [TICK_W-1:0] rst_pulse;
		logic [TICK_W-1:0] presence_wait;
		logic [TICK_W-1:0] reset_tail;
		logic [TICK_W-1:0] write_one_low;
		logic [TICK_W-1:0] write_one_tail;
		logic [TICK_W-1:0] write_zero_low;
		logic [TICK_W-1:0] write_zero_tail;
		logic [TICK_W-1:0] read_tail;
	} cfg_t;

	// Status after one beat
	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic              presence_fail;
		logic [BYTE_W-1:0] read_data;
	} res_t;

endpackage

// ===== hdl/owbm_cfg.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg
// Phase-length register file; write-only, one register per write beat.
// ----------------------------------------------------------------------------
module owbm_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [owbm_pkg::TICK_W-1:0]          cfg_data,
	output owbm_pkg::cfg_t                       cfg
);

	owbm_pkg::cfg_t cfg_q;

	// Register writes decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rst_pulse       <= owbm_pkg::RESET_LOW_DEF;
			cfg_q.presence_wait   <= owbm_pkg::PRESENCE_WAIT_DEF;
			cfg_q.reset_tail      <= owbm_pkg::RESET_TAIL_DEF;
			cfg_q.write_one_low   <= owbm_pkg::WRITE_ONE_LOW_DEF;
			cfg_q.write_one_tail  <= owbm_pkg::WRITE_ONE_TAIL_DEF;
			cfg_q.write_zero_low  <= owbm_pkg::WRITE_ZERO_LOW_DEF;
			cfg_q.write_zero_tail <= owbm_pkg::WRITE_ZERO_TAIL_DEF;
			cfg_q.read_tail       <= owbm_pkg::READ_TAIL_DEF;
		end else if (cfg_we) begin
			unique case (owbm_pkg::reg_idx_t'(cfg_idx))
				owbm_pkg::REG_RESET_LOW:       cfg_q.rst_pulse       <= cfg_data;
				owbm_pkg::REG_PRESENCE_WAIT:   cfg_q.presence_wait   <= cfg_data;
				owbm_pkg::REG_RESET_TAIL:      cfg_q.reset_tail      <= cfg_data;
				owbm_pkg::REG_WRITE_ONE_LOW:   cfg_q.write_one_low   <= cfg_data;
				owbm_pkg::REG_WRITE_ONE_TAIL:  cfg_q.write_one_tail  <= cfg_data;
				owbm_pkg::REG_WRITE_ZERO_LOW:  cfg_q.write_zero_low  <= cfg_data;
				owbm_pkg::REG_WRITE_ZERO_TAIL: cfg_q.write_zero_tail <= cfg_data;
				owbm_pkg::REG_READ_TAIL:       cfg_q.read_tail       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/owbm_core.sv =====
// ----------------------------------------------------------------------------
// owbm_core
// Bus phase sequencer: tick counter, slot shift register and bit counter.
// Updates its state on each accepted beat and presents the resulting status.
// ----------------------------------------------------------------------------
module owbm_core #(
	parameter int BITS_PER_BYTE = owbm_pkg::BITS_PER_BYTE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   func,
	input  logic [owbm_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         line_level,
	input  owbm_pkg::cfg_t               cfg,
	output owbm_pkg::res_t               res
);

	localparam int BL_W = $clog2(BITS_PER_BYTE + 1);
	localparam logic [BL_W-1:0] BITS_INIT = BL_W'(BITS_PER_BYTE);

	owbm_pkg::phase_t phase_q, phase_n;
	owbm_pkg::op_t    op_q, op_n;
	logic [owbm_pkg::BYTE_W-1:0] shift_q, shift_n;
	logic [BL_W-1:0]             bits_q, bits_n;
	logic [owbm_pkg::TICK_W-1:0] tick_q, tick_n, tick_dec;
	logic                        pres_q, pres_n;
	logic                        done;
	logic [owbm_pkg::BYTE_W-1:0] shift_sh;
	logic [BL_W-1:0]             bits_dec;

	// Floored decrements, and the one-bit shift used by write slots
	always_comb begin
		tick_dec = (tick_q != '0) ? tick_q - owbm_pkg::TICK_W'(1) : '0;
		bits_dec = (bits_q != '0) ? bits_q - BL_W'(1) : '0;
		shift_sh = shift_q >> 1;
	end

	// Next-state logic for one beat
	always_comb begin
		phase_n = phase_q;
		op_n    = op_q;
		shift_n = shift_q;
		bits_n  = bits_q;
		tick_n  = tick_q;
		pres_n  = pres_q;
		done    = 1'b0;
		if (owbm_pkg::func_t'(func) == owbm_pkg::FN_TICK) begin
			tick_n = tick_dec;
			if (tick_dec == '0) begin
				unique case (phase_q)
					owbm_pkg::PH_IDLE: ;
					owbm_pkg::PH_RST_LOW: begin
						phase_n = owbm_pkg::PH_RST_WAIT;
						tick_n  = cfg.presence_wait;
					end
					owbm_pkg::PH_RST_WAIT: begin
						pres_n  = line_level;
						phase_n = owbm_pkg::PH_RST_TAIL;
						tick_n  = cfg.reset_tail;
					end
					owbm_pkg::PH_RST_TAIL: begin
						phase_n = owbm_pkg::PH_IDLE;
						done    = 1'b1;
					end
					owbm_pkg::PH_WR_LOW: begin
						phase_n = owbm_pkg::PH_WR_TAIL;
						tick_n  = shift_q[0] ? cfg.write_one_tail : cfg.write_zero_tail;
					end
					owbm_pkg::PH_WR_TAIL: begin
						shift_n = shift_sh;
						bits_n  = bits_dec;
						if (bits_dec == '0) begin
							phase_n = owbm_pkg::PH_IDLE;
							done    = 1'b1;
						end else begin
							phase_n = owbm_pkg::PH_WR_LOW;
							tick_n  = shift_sh[0] ? cfg.write_one_low : cfg.write_zero_low;
						end
					end
					owbm_pkg::PH_RD_LOW: begin
						phase_n = owbm_pkg::PH_RD_WAIT;
						tick_n  = owbm_pkg::READ_WAIT_TICKS;
					end
					owbm_pkg::PH_RD_WAIT: begin
						shift_n = {line_level, shift_q[owbm_pkg::BYTE_W-1:1]};
						bits_n  = bits_dec;
						phase_n = owbm_pkg::PH_RD_TAIL;
						tick_n  = cfg.read_tail;
					end
					owbm_pkg::PH_RD_TAIL: begin
						if (bits_q == '0) begin
							phase_n = owbm_pkg::PH_IDLE;
							done    = 1'b1;
						end else begin
							phase_n = owbm_pkg::PH_RD_LOW;
							tick_n  = owbm_pkg::READ_LOW_TICKS;
						end
					end
					default: phase_n = owbm_pkg::PH_IDLE;
				endcase
			end
		end else if (phase_q == owbm_pkg::PH_IDLE) begin
			// Commands start an operation only when the bus is idle
			unique case (owbm_pkg::func_t'(func))
				owbm_pkg::FN_RESET: begin
					op_n    = owbm_pkg::OP_RESET;
					phase_n = owbm_pkg::PH_RST_LOW;
					tick_n  = cfg.rst_pulse;
				end
				owbm_pkg::FN_WRITE: begin
					op_n    = owbm_pkg::OP_WRITE;
					shift_n = data_byte;
					bits_n  = BITS_INIT;
					phase_n = owbm_pkg::PH_WR_LOW;
					tick_n  = data_byte[0] ? cfg.write_one_low : cfg.write_zero_low;
				end
				default: begin
					op_n    = owbm_pkg::OP_READ;
					shift_n = '0;
					bits_n  = BITS_INIT;
					phase_n = owbm_pkg::PH_RD_LOW;
					tick_n  = owbm_pkg::READ_LOW_TICKS;
				end
			endcase
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owbm_pkg::PH_IDLE;
			op_q    <= owbm_pkg::OP_NONE;
			shift_q <= '0;
			bits_q  <= '0;
			tick_q  <= '0;
			pres_q  <= 1'b1;
		end else if (accept) begin
			phase_q <= phase_n;
			op_q    <= op_n;
			shift_q <= shift_n;
			bits_q  <= bits_n;
			tick_q  <= tick_n;
			pres_q  <= pres_n;
		end
	end

	// Status seen after this beat
	always_comb begin
		res.drive_low     = (phase_n == owbm_pkg::PH_RST_LOW) ||
		                    (phase_n == owbm_pkg::PH_WR_LOW) ||
		                    (phase_n == owbm_pkg::PH_RD_LOW);
		res.busy_res      = (phase_n != owbm_pkg::PH_IDLE);
		res.done_res      = done;
		res.presence_fail = pres_n;
		res.read_data     = (op_n == owbm_pkg::OP_READ) ? shift_n : '0;
	end

endmodule

// ===== hdl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by tick beats, with a registered status output.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: each beat is a tick (every 5 us) or a command: bus reset
//   with presence check, byte write, or byte read. Commands that arrive while
//   an operation runs are dropped and do not count as a tick.
//   Output stream: exactly one status beat per input beat, in order: the line
//   drive, busy, done, the presence level and the byte read so far.
//   Config port: write phase lengths (in ticks) while the block is idle.
// Output timing: a status beat appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless m_tready stalls the output; the sequencer
//   updates on each accepted beat and the output register is refilled in the cycle it is drained.
// Reset: all registers but the output payload return to their defaults, the bus is
//   released, the presence level reads 1 and no output beat is pending.
// Stall: while the output beat waits on m_tready, s_tready stays low and the
//   sequencer holds its state.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
	parameter int BITS_PER_BYTE = owbm_pkg::BITS_PER_BYTE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,  // data_byte[7:0], line_level[8]
	input  logic [1:0]                           s_tuser,  // func[1:0]
	// Status stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// drive_low[0], busy_res[1], done_res[2], presence_fail[3], read_data[11:4]
	output logic [15:0]                          m_tdata,
	// Configuration writes
	input  logic                                 cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [owbm_pkg::TICK_W-1:0]          cfg_data
);

	owbm_pkg::cfg_t cfg;
	owbm_pkg::res_t res;
	logic           accept;
	logic           out_valid_q;
	logic [15:0]    out_data_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	owbm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	owbm_core #(
		.BITS_PER_BYTE (BITS_PER_BYTE)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.func       (s_tuser),
		.data_byte  (s_tdata[7:0]),
		.line_level (s_tdata[8]),
		.cfg        (cfg),
		.res        (res)
	);

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {4'b0000, res.read_data, res.presence_fail, res.done_res,
			               res.busy_res, res.drive_low};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	// Bus is only pulled low while an operation is running
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("line driven low while idle");

	// Completion always leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[1])
		else $error("done reported while still busy");

	// An empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	// Every accepted beat produces an output beat on the next cycle
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no output beat");
`endif

endmodule
